### sv/lpsc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the line position steering controller.
// Used by the channel interfaces, the sensor lanes, the divider and the top level.
// Depends on nothing.

package lpsc_pkg;

    // Sensor array and lane split.
    localparam int SENSOR_COUNT = 15;
    localparam int LANE_W       = 5;
    localparam int LANE_COUNT   = SENSOR_COUNT / LANE_W;
    localparam int LANE_HITS_W  = $clog2(LANE_W + 1);
    localparam int LANE_IDX_W   = $clog2(LANE_W * (LANE_W - 1) / 2 + 1);
    localparam int HITS_W       = $clog2(SENSOR_COUNT + 1);

    // Weight of sensor i is WEIGHT_TOP - 2*i.
    localparam int WEIGHT_TOP = 14;

    // Weighted sum of hits: magnitude up to 56, carried as 7-bit two's complement.
    localparam int SUM_W = 7;
    localparam int MAG_W = SUM_W - 1;

    // Iterative divider for the mean position.
    localparam int DIV_DVD_W = MAG_W;
    localparam int DIV_DVS_W = HITS_W;
    localparam int DIV_CNT_W = $clog2(DIV_DVD_W + 1);

    // Field widths.
    localparam int STEER_W = 12;
    localparam int HEAD_W  = 10;
    localparam int POS_W   = 5;
    localparam int PERIOD_W = 8;

    localparam logic [HEAD_W-1:0] HEAD_MAX = 10'd1000;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEER_CENTER = 3'd0,
        CFG_HEAD_CENTER  = 3'd1,
        CFG_STEER_MIN    = 3'd2,
        CFG_STEER_MAX    = 3'd3,
        CFG_HEAD_PERIOD  = 3'd4
    } cfg_reg_t;

    // Register values after reset.
    localparam logic [STEER_W-1:0]  STEER_CENTER_RST = 12'd1488;
    localparam logic [HEAD_W-1:0]   HEAD_CENTER_RST  = 10'd224;
    localparam logic [STEER_W-1:0]  STEER_MIN_RST    = 12'd1198;
    localparam logic [STEER_W-1:0]  STEER_MAX_RST    = 12'd1778;
    localparam logic [PERIOD_W-1:0] HEAD_PERIOD_RST  = 8'd17;

    // What one lane reports: hit count and sum of local indices of the hits.
    typedef struct packed {
        logic [LANE_HITS_W-1:0] hits;
        logic [LANE_IDX_W-1:0]  idx_sum;
    } lane_sum_t;

    // Divider status.
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

### sv/lpsc_in_if.sv
`timescale 1ns / 1ps
// Input channel: one frame of line-sensor bits per transaction.
// Depends on lpsc_pkg.

interface lpsc_in_if import lpsc_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [SENSOR_COUNT-1:0] sensor_bits;

    modport source (output valid, output sensor_bits, input ready);
    modport sink (input valid, input sensor_bits, output ready);
endinterface

### sv/lpsc_out_if.sv
`timescale 1ns / 1ps
// Output channel: steering and head duties plus status per transaction.
// Depends on lpsc_pkg.

interface lpsc_out_if import lpsc_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [STEER_W-1:0]       steer_duty;
    logic [HEAD_W-1:0]        head_duty;
    logic signed [POS_W-1:0]  line_position;
    logic                     no_line;
    logic                     head_updated;

    modport source (output valid, output steer_duty, output head_duty,
                    output line_position, output no_line, output head_updated,
                    input ready);
    modport sink (input valid, input steer_duty, input head_duty,
                  input line_position, input no_line, input head_updated,
                  output ready);
endinterface

### sv/lpsc_lane.sv
`timescale 1ns / 1ps
// One sensor lane: counts the hits in its group and sums their local indices.
// Depends on lpsc_pkg.

module lpsc_lane import lpsc_pkg::*;
(
    input  logic [LANE_W-1:0] bits,
    output lane_sum_t         result
);

    logic [LANE_HITS_W-1:0] hits;
    logic [LANE_IDX_W-1:0]  idx_sum;

    // Population count and index sum over the group.
    always_comb
    begin
        hits    = '0;
        idx_sum = '0;
        for (int j = 0; j < LANE_W; j++)
        begin
            if (bits[j])
            begin
                hits    = hits + LANE_HITS_W'(1);
                idx_sum = idx_sum + LANE_IDX_W'(j);
            end
        end
    end

    assign result.hits    = hits;
    assign result.idx_sum = idx_sum;

endmodule

### sv/lpsc_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, for the mean line position.
// Depends on lpsc_pkg.

module lpsc_div import lpsc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_DVD_W-1:0] dividend,
    input  logic [DIV_DVS_W-1:0] divisor,
    output div_stat_t            stat,
    output logic [DIV_DVD_W-1:0] quotient
);

    logic [DIV_CNT_W-1:0] count_reg;
    logic                 done_reg;
    logic [DIV_DVS_W-1:0] rem_reg;
    logic [DIV_DVS_W-1:0] dvs_reg;
    logic [DIV_DVD_W-1:0] quo_reg;

    logic [DIV_DVS_W:0]   trial;
    logic                 fits;

    // Bring down the next dividend bit and try a subtraction.
    assign trial = {rem_reg, quo_reg[DIV_DVD_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    // Control: step counter and completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                count_reg <= DIV_CNT_W'(DIV_DVD_W);
            end
            else if (count_reg != '0)
            begin
                count_reg <= count_reg - DIV_CNT_W'(1);
                done_reg  <= (count_reg == DIV_CNT_W'(1));
            end
        end
    end

    // Datapath: partial remainder and the dividend shifting into the quotient.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvs_reg <= divisor;
            quo_reg <= dividend;
        end
        else if (count_reg != '0)
        begin
            rem_reg <= fits ? DIV_DVS_W'(trial - {1'b0, dvs_reg}) : trial[DIV_DVS_W-1:0];
            quo_reg <= {quo_reg[DIV_DVD_W-2:0], fits};
        end
    end

    assign stat.busy = (count_reg != '0);
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

### sv/line_position_steering_controller.sv
`timescale 1ns / 1ps
// Line position steering controller: usage notes.
// A frame of sensor bits arrives on the frame channel; one transaction on the
// command channel answers it with the clamped steering duty, the head servo
// duty, the line position and two status flags. Registers are written on the
// plain cfg port (cfg_wr_en, cfg_index, cfg_data); the user must write them
// only while no frame is in flight, since the block does not enforce it.
// A frame with at least one hit goes through the six-step restoring divider
// that forms the mean position; a frame with no hit skips it. The three sensor
// lanes and the merge are combinational on the frame; the control law then
// forms its terms and its quotients, and the result is loaded for output.
// A result sits in the output register until taken; the next frame is then
// already accepted and worked on, and it waits in its last step only while
// the earlier result has not been taken.
// Reset clears all control state, loads the register reset values, sets the
// head duty to the reset head centre and clears the position and history.
// Depends on lpsc_pkg, lpsc_in_if, lpsc_out_if, lpsc_lane and lpsc_div.

module line_position_steering_controller import lpsc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    lpsc_in_if.sink               frame,
    lpsc_out_if.source            command
);

    // Reciprocal constants for exact division of small magnitudes.
    localparam int RECIP11 = 11916;
    localparam int SHIFT11 = 17;
    localparam int RECIP5  = 52;
    localparam int RECIP6  = 43;
    localparam int SHIFT56 = 8;
    localparam int MRG_W   = SUM_W + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_PD,
        S_Q,
        S_OUT
    } state_t;

    // Configuration registers.
    logic [STEER_W-1:0]  steer_center_reg;
    logic [HEAD_W-1:0]   head_center_reg;
    logic [STEER_W-1:0]  steer_min_reg;
    logic [STEER_W-1:0]  steer_max_reg;
    logic [PERIOD_W-1:0] head_period_reg;

    // Sequencer and controller state.
    state_t                    state_reg;
    logic signed [POS_W-1:0]   held_position_reg;
    logic [HEAD_W-1:0]         head_duty_reg;
    logic signed [HEAD_W:0]    prev_offset_reg;
    logic signed [7:0]         inc_last_reg;
    logic signed [7:0]         inc_before_reg;
    logic [PERIOD_W-1:0]       frame_counter_reg;

    // Per-frame working registers.
    logic                      none_reg;
    logic                      sum_neg_reg;
    logic                      due_reg;
    logic                      bypass_reg;
    logic signed [14:0]        pd_reg;
    logic signed [14:0]        n5_reg;
    logic                      inc_zero_reg;
    logic                      div5_reg;
    logic signed [7:0]         np_reg;
    logic signed [9:0]         nd_reg;
    logic signed [10:0]        q_steer_reg;
    logic signed [4:0]         q_pos_reg;
    logic signed [5:0]         q_d_reg;

    // Output register.
    logic                      out_valid_reg;
    logic [STEER_W-1:0]        out_steer_reg;
    logic [HEAD_W-1:0]         out_head_reg;
    logic signed [POS_W-1:0]   out_pos_reg;
    logic                      out_none_reg;
    logic                      out_upd_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steer_center_reg <= STEER_CENTER_RST;
            head_center_reg  <= HEAD_CENTER_RST;
            steer_min_reg    <= STEER_MIN_RST;
            steer_max_reg    <= STEER_MAX_RST;
            head_period_reg  <= HEAD_PERIOD_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_STEER_CENTER: steer_center_reg <= cfg_data[STEER_W-1:0];
                CFG_HEAD_CENTER:  head_center_reg  <= cfg_data[HEAD_W-1:0];
                CFG_STEER_MIN:    steer_min_reg    <= cfg_data[STEER_W-1:0];
                CFG_STEER_MAX:    steer_max_reg    <= cfg_data[STEER_W-1:0];
                CFG_HEAD_PERIOD:  head_period_reg  <= cfg_data[PERIOD_W-1:0];
                default:          ;
            endcase
        end
    end

    // Sensor lanes.
    lane_sum_t lane_res [LANE_COUNT];

    for (genvar l = 0; l < LANE_COUNT; l++)
    begin : g_lane
        lpsc_lane u_lane
        (
            .bits   (frame.sensor_bits[l*LANE_W +: LANE_W]),
            .result (lane_res[l])
        );
    end

    // Merge the lanes into the total hit count and weighted sum.
    logic signed [MRG_W-1:0] sum_acc;
    logic [HITS_W-1:0]       hits_total;
    logic signed [SUM_W-1:0] sum_total;
    logic [MAG_W-1:0]        sum_mag;

    always_comb
    begin
        sum_acc    = '0;
        hits_total = '0;
        for (int l = 0; l < LANE_COUNT; l++)
        begin
            hits_total = hits_total + HITS_W'(lane_res[l].hits);
            sum_acc    = sum_acc + MRG_W'(int'(lane_res[l].hits) * (WEIGHT_TOP - 2 * LANE_W * l)
                                          - 2 * int'(lane_res[l].idx_sum));
        end
        sum_total = sum_acc[SUM_W-1:0];
        sum_mag   = sum_total[SUM_W-1] ? MAG_W'(-sum_total) : sum_total[MAG_W-1:0];
    end

    // Mean position divider.
    logic                  accept;
    logic                  div_start;
    div_stat_t             div_stat;
    logic [DIV_DVD_W-1:0]  div_quo;

    assign accept    = frame.valid && frame.ready;
    assign div_start = accept && (hits_total != '0);

    lpsc_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_mag),
        .divisor  (hits_total),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    // Control law terms from the current head offset and position.
    logic signed [HEAD_W:0]  off;
    logic [HEAD_W-1:0]       off_abs;
    logic signed [11:0]      off_diff;
    logic [3:0]              kp;
    logic [2:0]              ko;
    logic signed [14:0]      pd_next;
    logic signed [14:0]      n5_next;
    logic [POS_W-1:0]        pos_abs;
    logic signed [7:0]       pos8;
    logic signed [8:0]       d9;
    logic signed [9:0]       d10;
    logic signed [7:0]       np_next;
    logic signed [9:0]       nd_next;
    logic [PERIOD_W-1:0]     cnt_inc;

    always_comb
    begin
        off      = $signed({1'b0, head_duty_reg}) - $signed({1'b0, head_center_reg});
        off_abs  = off[HEAD_W] ? HEAD_W'(-off) : off[HEAD_W-1:0];
        off_diff = {off[HEAD_W], off} - {prev_offset_reg[HEAD_W], prev_offset_reg};

        // Gain bands of the steering law.
        if (off_abs <= 10'd14)
        begin
            kp = 4'd4;  ko = 3'd1;
        end
        else if (off_abs <= 10'd24)
        begin
            kp = 4'd6;  ko = 3'd3;
        end
        else if (off_abs <= 10'd40)
        begin
            kp = 4'd8;  ko = 3'd4;
        end
        else if (off_abs <= 10'd60)
        begin
            kp = 4'd9;  ko = 3'd5;
        end
        else if (off_abs <= 10'd80)
        begin
            kp = 4'd11; ko = 3'd6;
        end
        else
        begin
            kp = 4'd11; ko = 3'd7;
        end

        pd_next = $signed({{10{held_position_reg[POS_W-1]}}, held_position_reg})
                  * $signed({11'd0, kp})
                  + $signed({{4{off[HEAD_W]}}, off}) * $signed({12'd0, ko});
        n5_next = $signed({{3{off_diff[11]}}, off_diff}) * 15'sd5;

        // Head increment numerators.
        pos_abs = held_position_reg[POS_W-1] ? POS_W'(-held_position_reg)
                                             : held_position_reg;
        pos8    = {{3{held_position_reg[POS_W-1]}}, held_position_reg};
        d9      = {inc_last_reg[7], inc_last_reg} - {inc_before_reg[7], inc_before_reg};
        d10     = {d9[8], d9};
        if (pos_abs >= 5'd8 && pos_abs <= 5'd10)
            np_next = pos8 * 8'sd5;
        else
            np_next = pos8 <<< 2;
        if (pos_abs <= 5'd7)
            nd_next = d10 * 10'sd3;
        else
            nd_next = d10 <<< 2;

        cnt_inc = frame_counter_reg + PERIOD_W'(1);
    end

    // Reciprocal divisions on magnitudes, then the sign put back.
    logic [13:0] m5;
    logic [27:0] prod5;
    logic [10:0] q5;
    logic [6:0]  mp;
    logic [12:0] prod_p;
    logic [3:0]  qp;
    logic [8:0]  md;
    logic [22:0] prod_d;
    logic [4:0]  qd;

    always_comb
    begin
        m5     = n5_reg[14] ? 14'(-n5_reg) : n5_reg[13:0];
        prod5  = 28'(m5) * 28'(RECIP11);
        q5     = 11'(prod5 >> SHIFT11);
        mp     = np_reg[7] ? 7'(-np_reg) : np_reg[6:0];
        prod_p = 13'(mp) * (div5_reg ? 13'(RECIP5) : 13'(RECIP6));
        qp     = 4'(prod_p >> SHIFT56);
        md     = nd_reg[9] ? 9'(-nd_reg) : nd_reg[8:0];
        prod_d = 23'(md) * 23'(RECIP11);
        qd     = 5'(prod_d >> SHIFT11);
    end

    // Final sums and clamps.
    logic signed [15:0]  steer_raw;
    logic [STEER_W-1:0]  steer_clamped;
    logic signed [7:0]   inc;
    logic signed [11:0]  head_sum;
    logic [HEAD_W-1:0]   head_new;
    logic                out_free;
    logic                out_load;

    always_comb
    begin
        steer_raw = $signed({4'd0, steer_center_reg})
                    - $signed({pd_reg[14], pd_reg})
                    - $signed({{5{q_steer_reg[10]}}, q_steer_reg});
        if (steer_raw > $signed({4'd0, steer_max_reg}))
            steer_clamped = steer_max_reg;
        else if (steer_raw < $signed({4'd0, steer_min_reg}))
            steer_clamped = steer_min_reg;
        else
            steer_clamped = steer_raw[STEER_W-1:0];

        inc      = $signed({{3{q_pos_reg[4]}}, q_pos_reg}) + $signed({{2{q_d_reg[5]}}, q_d_reg});
        head_sum = $signed({2'd0, head_duty_reg}) + $signed({{4{inc[7]}}, inc});
        if (head_sum < 12'sd0)
            head_new = '0;
        else if (head_sum > $signed({2'd0, HEAD_MAX}))
            head_new = HEAD_MAX;
        else
            head_new = head_sum[HEAD_W-1:0];

        out_free = !out_valid_reg || command.ready;
        out_load = (state_reg == S_OUT) && out_free;
    end

    // Sequencer: state, controller history and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            held_position_reg <= '0;
            head_duty_reg     <= HEAD_CENTER_RST;
            prev_offset_reg   <= '0;
            inc_last_reg      <= '0;
            inc_before_reg    <= '0;
            frame_counter_reg <= '0;
            none_reg          <= 1'b0;
            sum_neg_reg       <= 1'b0;
            due_reg           <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            // A new result replaces a taken one in the same cycle.
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (command.valid && command.ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        none_reg    <= (hits_total == '0);
                        sum_neg_reg <= sum_total[SUM_W-1];
                        state_reg   <= (hits_total == '0) ? S_PD : S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_stat.done)
                    begin
                        held_position_reg <= sum_neg_reg ? POS_W'(-div_quo) : POS_W'(div_quo);
                        state_reg         <= S_PD;
                    end
                end
                S_PD:
                begin
                    prev_offset_reg <= off;
                    if (cnt_inc >= head_period_reg)
                    begin
                        due_reg           <= 1'b1;
                        frame_counter_reg <= PERIOD_W'(1);
                    end
                    else
                    begin
                        due_reg           <= 1'b0;
                        frame_counter_reg <= cnt_inc;
                    end
                    state_reg <= S_Q;
                end
                S_Q:
                begin
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        if (due_reg)
                        begin
                            head_duty_reg  <= head_new;
                            inc_last_reg   <= inc;
                            inc_before_reg <= inc_last_reg;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Law terms and output payload.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_PD)
        begin
            bypass_reg   <= (off_abs <= 10'd8);
            pd_reg       <= pd_next;
            n5_reg       <= n5_next;
            inc_zero_reg <= (pos_abs <= 5'd1);
            div5_reg     <= (pos_abs <= 5'd3);
            np_reg       <= np_next;
            nd_reg       <= nd_next;
        end
        if (state_reg == S_Q)
        begin
            q_steer_reg <= bypass_reg ? 11'sd0 : (n5_reg[14] ? -$signed(q5) : $signed(q5));
            q_pos_reg   <= inc_zero_reg ? 5'sd0
                         : (np_reg[7] ? -$signed({1'b0, qp}) : $signed({1'b0, qp}));
            q_d_reg     <= inc_zero_reg ? 6'sd0
                         : (nd_reg[9] ? -$signed({1'b0, qd}) : $signed({1'b0, qd}));
            if (bypass_reg)
                pd_reg <= '0;
        end
        if (out_load)
        begin
            out_steer_reg <= steer_clamped;
            out_head_reg  <= due_reg ? head_new : head_duty_reg;
            out_pos_reg   <= held_position_reg;
            out_none_reg  <= none_reg;
            out_upd_reg   <= due_reg;
        end
    end

    assign frame.ready           = (state_reg == S_IDLE);
    assign command.valid         = out_valid_reg;
    assign command.steer_duty    = out_steer_reg;
    assign command.head_duty     = out_head_reg;
    assign command.line_position = out_pos_reg;
    assign command.no_line       = out_none_reg;
    assign command.head_updated  = out_upd_reg;

    // Checks on the sequencer and the controller state.
    assert property (@(posedge clk) disable iff (!rst_n)
        head_duty_reg <= HEAD_MAX)
        else $error("head duty left its saturation range");

    assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == S_DIV)
        else $error("divider finished outside the divide step");

    assert property (@(posedge clk) disable iff (!rst_n)
        frame.ready |-> !div_stat.busy)
        else $error("frame channel ready while the divider is busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_Q && due_reg) |-> frame_counter_reg == PERIOD_W'(1))
        else $error("frame counter not restarted on a head update");

    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> state_reg == S_DIV && div_stat.busy)
        else $error("divider not running after a frame with hits");

endmodule

### verif/tb_line_position_steering_controller.sv
`timescale 1ns / 1ps
// Self-checking testbench for the line position steering controller.
// Sends sensor frames, predicts every command in step and compares it field by field.
// Depends on lpsc_pkg, lpsc_in_if, lpsc_out_if and line_position_steering_controller.

module tb_line_position_steering_controller import lpsc_pkg::*;;

    localparam int SETTLE_CYCLES  = 12;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_FRAMES  = 1050;
    localparam int MAX_REPORTS    = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    // One steering command as the block should present it.
    typedef struct packed {
        logic [STEER_W-1:0]      steer_duty;
        logic [HEAD_W-1:0]       head_duty;
        logic signed [POS_W-1:0] line_position;
        logic                    no_line;
        logic                    head_updated;
    } steer_command_t;

    logic clk = 1'b0;
    logic rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    lpsc_in_if  frame_ch ();
    lpsc_out_if command_ch ();

    line_position_steering_controller uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .frame     (frame_ch),
        .command   (command_ch)
    );

    // Predicted configuration and controller state.
    int cfg_steer_center = int'(STEER_CENTER_RST);
    int cfg_head_center  = int'(HEAD_CENTER_RST);
    int cfg_steer_min    = int'(STEER_MIN_RST);
    int cfg_steer_max    = int'(STEER_MAX_RST);
    int cfg_head_period  = int'(HEAD_PERIOD_RST);

    int pos_hold            = 0;
    int head_duty_now       = int'(HEAD_CENTER_RST);
    int last_offset         = 0;
    int inc_latest          = 0;
    int inc_previous        = 0;
    int frames_since_update = 0;

    steer_command_t pending_commands[$];

    int  mismatch_count  = 0;
    int  frames_sent     = 0;
    int  results_checked = 0;
    int  no_line_frames  = 0;
    int  head_updates    = 0;
    int  reg_writes      = 0;
    int  idle_cycles     = 0;
    int  track_centre    = 7;
    bit  source_gaps_on  = 1'b1;
    bit  sink_stalls_on  = 1'b1;

    // Clock with a 4 ns period.
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Works out the command for one frame and advances the predicted state.
    function automatic steer_command_t predict_command(input logic [SENSOR_COUNT-1:0] bits);
        int weight_sum;
        int hit_count;
        int off;
        int mag;
        int steer;
        int kp;
        int ko;
        int p;
        int d;
        int inc;
        bit updated;
        steer_command_t cmd;
        weight_sum = 0;
        hit_count  = 0;
        updated    = 1'b0;
        for (int i = 0; i < SENSOR_COUNT; i++)
        begin
            if (bits[i])
            begin
                weight_sum += WEIGHT_TOP - 2 * i;
                hit_count++;
            end
        end
        if (hit_count != 0)
            pos_hold = weight_sum / hit_count;

        // Steering law on the current head offset.
        off = head_duty_now - cfg_head_center;
        mag = (off < 0) ? -off : off;
        if (mag <= 8)
            steer = cfg_steer_center;
        else
        begin
            if (mag <= 14)      begin kp = 4;  ko = 1; end
            else if (mag <= 24) begin kp = 6;  ko = 3; end
            else if (mag <= 40) begin kp = 8;  ko = 4; end
            else if (mag <= 60) begin kp = 9;  ko = 5; end
            else if (mag <= 80) begin kp = 11; ko = 6; end
            else                begin kp = 11; ko = 7; end
            steer = cfg_steer_center - (kp * pos_hold + ko * off)
                    - (5 * (off - last_offset)) / 11;
        end
        // An inverted clamp gives the upper bound when steer is above it, else the lower bound.
        if (steer > cfg_steer_max)
            steer = cfg_steer_max;
        else if (steer < cfg_steer_min)
            steer = cfg_steer_min;
        last_offset = off;

        // Frame counter and head servo update.
        frames_since_update = (frames_since_update + 1) & 8'hFF;
        if (frames_since_update >= cfg_head_period)
        begin
            frames_since_update = 1;
            updated = 1'b1;
            p = (pos_hold < 0) ? -pos_hold : pos_hold;
            d = inc_latest - inc_previous;
            if (p <= 1)       inc = 0;
            else if (p <= 3)  inc = (4 * pos_hold) / 5 + (3 * d) / 11;
            else if (p <= 7)  inc = (4 * pos_hold) / 6 + (3 * d) / 11;
            else if (p <= 10) inc = (5 * pos_hold) / 6 + (4 * d) / 11;
            else              inc = (4 * pos_hold) / 6 + (4 * d) / 11;
            inc_previous = inc_latest;
            inc_latest   = inc;
            head_duty_now += inc;
            if (head_duty_now < 0)
                head_duty_now = 0;
            if (head_duty_now > int'(HEAD_MAX))
                head_duty_now = int'(HEAD_MAX);
        end

        cmd.steer_duty    = steer[STEER_W-1:0];
        cmd.head_duty     = head_duty_now[HEAD_W-1:0];
        cmd.line_position = pos_hold[POS_W-1:0];
        cmd.no_line       = (hit_count == 0);
        cmd.head_updated  = updated;
        return cmd;
    endfunction

    // A short run of hits around one sensor, like a real line under the array.
    function automatic logic [SENSOR_COUNT-1:0] line_frame(input int centre);
        logic [SENSOR_COUNT-1:0] bits;
        int width;
        int lo;
        bits  = '0;
        width = $urandom_range(1, 3);
        lo    = centre - int'($urandom_range(0, width - 1));
        for (int i = 0; i < width; i++)
        begin
            if (lo + i >= 0 && lo + i < SENSOR_COUNT)
                bits[lo + i] = 1'b1;
        end
        return bits;
    endfunction

    // Mostly a wandering line, with lost-line frames and noise mixed in.
    function automatic logic [SENSOR_COUNT-1:0] random_frame();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            return '0;
        if (pick < 25)
            return SENSOR_COUNT'($urandom);
        if (pick < 30)
            track_centre = $urandom_range(0, SENSOR_COUNT - 1);
        else
            track_centre += int'($urandom_range(0, 2)) - 1;
        if (track_centre < 0)
            track_centre = 0;
        if (track_centre > SENSOR_COUNT - 1)
            track_centre = SENSOR_COUNT - 1;
        return line_frame(track_centre);
    endfunction

    // Sends one frame, records its prediction on acceptance, then maybe idles.
    task automatic send_frame(input logic [SENSOR_COUNT-1:0] bits);
        steer_command_t cmd;
        int gap;
        frame_ch.valid       <= 1'b1;
        frame_ch.sensor_bits <= bits;
        do
            @(posedge clk);
        while (frame_ch.ready !== 1'b1);
        cmd = predict_command(bits);
        pending_commands.push_back(cmd);
        frames_sent++;
        if (cmd.no_line)
            no_line_frames++;
        if (cmd.head_updated)
            head_updates++;
        gap = (source_gaps_on && $urandom_range(0, 99) < 40) ? pick_gap() : 0;
        if (gap > 0)
        begin
            frame_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Holds the sender back until every predicted command has arrived.
    task automatic wait_for_results();
        frame_ch.valid <= 1'b0;
        while (pending_commands.size() != 0)
            @(posedge clk);
    endtask

    // Drains the block and lets its pipeline settle before a register write.
    task automatic quiesce();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes one register and mirrors it in the predicted configuration.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        reg_writes++;
        case (idx)
            CFG_STEER_CENTER: cfg_steer_center = int'(data[STEER_W-1:0]);
            CFG_HEAD_CENTER:  cfg_head_center  = int'(data[HEAD_W-1:0]);
            CFG_STEER_MIN:    cfg_steer_min    = int'(data[STEER_W-1:0]);
            CFG_STEER_MAX:    cfg_steer_max    = int'(data[STEER_W-1:0]);
            CFG_HEAD_PERIOD:  cfg_head_period  = int'(data[PERIOD_W-1:0]);
            default: ;
        endcase
    endtask

    // Extremes of the sensor field, every single sensor and the lost line.
    task automatic test_directed_frames();
        logic [SENSOR_COUNT-1:0] patterns[$];
        patterns = '{15'h0000, 15'h7FFF};
        for (int i = 0; i < SENSOR_COUNT; i++)
            patterns.push_back(SENSOR_COUNT'(1) << i);
        patterns.push_back(15'h0003);
        patterns.push_back(15'h6000);
        patterns.push_back(15'h5555);
        patterns.push_back(15'h2AAA);
        patterns.push_back(15'h0011);
        patterns.push_back(15'h4400);
        patterns.push_back(15'h0000);
        patterns.push_back(15'h0007);
        foreach (patterns[k])
        begin
            send_frame(patterns[k]);
            // One stop mid-run until the block has answered everything.
            if (k == 12)
                wait_for_results();
        end
    endtask

    // Drives the head servo into both end stops with a fast update rate.
    task automatic test_head_saturation();
        quiesce();
        write_reg(CFG_HEAD_PERIOD, 12'd1);
        repeat (110) send_frame(line_frame($urandom_range(0, 2)));
        repeat (230) send_frame(line_frame($urandom_range(12, 14)));
    endtask

    // Clamp and centre extremes, the inverted clamp among them.
    task automatic test_clamp_settings();
        quiesce();
        write_reg(CFG_HEAD_PERIOD, 12'd3);
        write_reg(CFG_STEER_MIN, 12'd3000);
        write_reg(CFG_STEER_MAX, 12'd1000);
        repeat (30) send_frame(random_frame());
        quiesce();
        write_reg(CFG_STEER_CENTER, 12'd0);
        write_reg(CFG_STEER_MIN, 12'd0);
        write_reg(CFG_STEER_MAX, 12'hFFF);
        repeat (30) send_frame(random_frame());
        quiesce();
        write_reg(CFG_STEER_CENTER, 12'hFFF);
        repeat (30) send_frame(random_frame());
        quiesce();
        write_reg(CFG_HEAD_CENTER, 12'd0);
        repeat (30) send_frame(random_frame());
        quiesce();
        write_reg(CFG_HEAD_CENTER, 12'd1000);
        repeat (30) send_frame(random_frame());
        // A centre above the servo range is written; the register keeps its low ten bits.
        quiesce();
        write_reg(CFG_HEAD_CENTER, 12'hFFF);
        repeat (30) send_frame(random_frame());
        quiesce();
        write_reg(CFG_STEER_CENTER, 12'(STEER_CENTER_RST));
        write_reg(CFG_HEAD_CENTER, 12'(HEAD_CENTER_RST));
        write_reg(CFG_STEER_MIN, 12'(STEER_MIN_RST));
        write_reg(CFG_STEER_MAX, 12'(STEER_MAX_RST));
        repeat (30) send_frame(random_frame());
    endtask

    // Longest period, a counter left above a smaller period, the zero period and an unused index.
    task automatic test_period_counter();
        quiesce();
        write_reg(CFG_HEAD_PERIOD, 12'h0FF);
        repeat (200) send_frame(random_frame());
        quiesce();
        write_reg(CFG_HEAD_PERIOD, 12'd5);
        repeat (20) send_frame(random_frame());
        quiesce();
        write_reg(CFG_HEAD_PERIOD, 12'hF00);
        repeat (20) send_frame(random_frame());
        quiesce();
        write_reg(CFG_UNUSED, 12'hABC);
        write_reg(CFG_HEAD_PERIOD, 12'(HEAD_PERIOD_RST));
        repeat (10) send_frame(random_frame());
    endtask

    // Phases of random frames, each under freshly drawn settings.
    task automatic test_random_settings();
        int sent;
        int phase_len;
        int pick;
        int near;
        int lo;
        sent = 0;
        while (sent < RANDOM_FRAMES)
        begin
            phase_len = $urandom_range(40, 220);
            quiesce();
            if ($urandom_range(0, 99) < 60)
                write_reg(CFG_STEER_CENTER, ($urandom_range(0, 1) == 1) ?
                          12'($urandom_range(1300, 1700)) : 12'($urandom));
            if ($urandom_range(0, 99) < 60)
            begin
                pick = $urandom_range(0, 99);
                near = head_duty_now + int'($urandom_range(0, 180)) - 90;
                if (near < 0)
                    near = 0;
                if (near > 1023)
                    near = 1023;
                if (pick < 40)
                    write_reg(CFG_HEAD_CENTER, 12'(near));
                else if (pick < 80)
                    write_reg(CFG_HEAD_CENTER, 12'($urandom_range(200, 260)));
                else
                    write_reg(CFG_HEAD_CENTER, 12'($urandom));
            end
            if ($urandom_range(0, 99) < 60)
            begin
                if ($urandom_range(0, 99) < 70)
                begin
                    lo = $urandom_range(0, 1500);
                    write_reg(CFG_STEER_MIN, 12'(lo));
                    write_reg(CFG_STEER_MAX, 12'($urandom_range(1500, 4095)));
                end
                else
                begin
                    write_reg(CFG_STEER_MIN, 12'($urandom));
                    write_reg(CFG_STEER_MAX, 12'($urandom));
                end
            end
            if ($urandom_range(0, 99) < 60)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 50)
                    write_reg(CFG_HEAD_PERIOD, 12'($urandom_range(1, 20)));
                else if (pick < 80)
                    write_reg(CFG_HEAD_PERIOD, 12'($urandom));
                else
                    write_reg(CFG_HEAD_PERIOD, 12'($urandom_range(0, 3)));
            end
            source_gaps_on = ($urandom_range(0, 3) != 0);
            sink_stalls_on = ($urandom_range(0, 3) != 0);
            repeat (phase_len)
            begin
                send_frame(random_frame());
                if ($urandom_range(0, 199) == 0)
                    wait_for_results();
            end
            sent += phase_len;
        end
        source_gaps_on = 1'b1;
        sink_stalls_on = 1'b1;
    endtask

    // Main sequence: reset once, then the tests in turn.
    initial
    begin
        rst_n                <= 1'b0;
        cfg_wr_en            <= 1'b0;
        cfg_index            <= CFG_STEER_CENTER;
        cfg_data             <= '0;
        frame_ch.valid       <= 1'b0;
        frame_ch.sensor_bits <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_frames();
        test_head_saturation();
        test_clamp_settings();
        test_period_counter();
        test_random_settings();
        quiesce();

        if (pending_commands.size() != 0)
            mismatch_count += pending_commands.size();
        $display("Sent %0d frames (%0d with no line, %0d head updates), checked %0d commands,",
                 frames_sent, no_line_frames, head_updates, results_checked);
        $display("across %0d register writes; %0d mismatches.", reg_writes, mismatch_count);
        if (mismatch_count == 0)
            $display("tb_line_position_steering_controller: done, clean");
        else
            $display("tb_line_position_steering_controller: done, errors");
        $finish;
    end

    // Command receiver: ready with random stalls of random length.
    initial
    begin
        int stall_left;
        stall_left = 0;
        command_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                command_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (sink_stalls_on && $urandom_range(0, 99) < 30)
            begin
                command_ch.ready <= 1'b0;
                stall_left = pick_gap() - 1;
            end
            else
                command_ch.ready <= 1'b1;
        end
    end

    // Compares each accepted command transaction with the oldest prediction.
    always @(posedge clk)
    begin
        steer_command_t want;
        if (rst_n === 1'b1 && command_ch.valid === 1'b1 && command_ch.ready === 1'b1)
        begin
            results_checked++;
            if (pending_commands.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("Unexpected command: steer %0d head %0d pos %0d no_line %0b upd %0b",
                             command_ch.steer_duty, command_ch.head_duty,
                             $signed(command_ch.line_position), command_ch.no_line,
                             command_ch.head_updated);
            end
            else
            begin
                want = pending_commands.pop_front();
                if (command_ch.steer_duty    !== want.steer_duty    ||
                    command_ch.head_duty     !== want.head_duty     ||
                    command_ch.line_position !== want.line_position ||
                    command_ch.no_line       !== want.no_line       ||
                    command_ch.head_updated  !== want.head_updated)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $display("Command %0d mismatch at %0t (expected / actual):",
                                 results_checked, $realtime);
                        $display("  steer %0d/%0d head %0d/%0d pos %0d/%0d no_line %0b/%0b upd %0b/%0b",
                                 want.steer_duty, command_ch.steer_duty,
                                 want.head_duty, command_ch.head_duty,
                                 $signed(want.line_position), $signed(command_ch.line_position),
                                 want.no_line, command_ch.no_line,
                                 want.head_updated, command_ch.head_updated);
                    end
                end
            end
        end
    end

    // Watchdog: too long without any transaction on either channel ends the run.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if ((frame_ch.valid === 1'b1 && frame_ch.ready === 1'b1) ||
                (command_ch.valid === 1'b1 && command_ch.ready === 1'b1))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog: no transaction for %0d cycles.", WATCHDOG_LIMIT);
                $display("tb_line_position_steering_controller: done, errors");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
